// ===== src/bms_pkg.sv =====
// shared constants, codes and request/result types for the bounded multiset store
package bms_pkg;

  // bag geometry
  localparam int BAG_DEPTH  = 16;
  localparam int ITEM_WIDTH = 32;

  // count holds 0..BAG_DEPTH, index holds 0..BAG_DEPTH-1
  localparam int CNT_W = $clog2(BAG_DEPTH + 1);
  localparam int IDX_W = (BAG_DEPTH > 1) ? $clog2(BAG_DEPTH) : 1;

  // port field widths
  localparam int ACT_W     = 2;
  localparam int VALUE_W   = 32;
  localparam int OUT_CNT_W = 5;
  localparam int OUT_DATA_W = 16;

  // action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_COUNT  = 2'd2,
    ACT_CLEAR  = 2'd3
  } bms_action_t;

  // request handed to the engine
  typedef struct packed {
    bms_action_t           action;
    logic [ITEM_WIDTH-1:0] value;
  } bms_req_t;

  // result handed back by the engine
  typedef struct packed {
    logic                 ok;
    logic [OUT_CNT_W-1:0] match_count;
    logic [OUT_CNT_W-1:0] fill_count;
  } bms_res_t;

endpackage

// ===== src/bms_engine.sv =====
// entry memory and scan sequencer: one compare per cycle over the stored entries
module bms_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  input  bms_pkg::bms_req_t req,
  output logic             req_ready,
  output logic             res_valid,
  output bms_pkg::bms_res_t res,
  input  logic             res_ready
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  // entry memory
  logic [bms_pkg::ITEM_WIDTH-1:0] mem [bms_pkg::BAG_DEPTH];

  state_t                         state_r, state_nxt;
  bms_pkg::bms_action_t           act_r, act_nxt;
  logic [bms_pkg::ITEM_WIDTH-1:0] val_r, val_nxt;
  logic [bms_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [bms_pkg::CNT_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic [bms_pkg::CNT_W-1:0]      match_r, match_nxt;
  logic                           found_r, found_nxt;
  logic                           data_vld_r;
  logic [bms_pkg::IDX_W-1:0]      data_idx_r;
  logic [bms_pkg::ITEM_WIDTH-1:0] rd_data_r;

  logic                           issue;
  logic                           hit;
  logic                           room;
  logic                           shift_wr;
  logic                           add_wr;
  logic                           wr_en;
  logic [bms_pkg::IDX_W-1:0]      wr_addr;
  logic [bms_pkg::ITEM_WIDTH-1:0] wr_data;
  logic [bms_pkg::CNT_W-1:0]      fin_cnt;
  logic                           fin_ok;

  // scan datapath controls
  assign issue    = (state_r == S_SCAN) && (rd_idx_r < cnt_r);
  assign hit      = data_vld_r && (rd_data_r == val_r);
  assign room     = cnt_r < bms_pkg::CNT_W'(bms_pkg::BAG_DEPTH);
  assign shift_wr = data_vld_r && (act_r == bms_pkg::ACT_REMOVE) && found_r;
  assign add_wr   = (state_r == S_FIN) && res_ready && (act_r == bms_pkg::ACT_ADD) && room;

  // single write port: shift down on remove, append on add
  assign wr_en   = shift_wr || add_wr;
  assign wr_addr = shift_wr ? (data_idx_r - 1'b1) : cnt_r[bms_pkg::IDX_W-1:0];
  assign wr_data = shift_wr ? rd_data_r : val_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r  <= mem[rd_idx_r[bms_pkg::IDX_W-1:0]];
      data_idx_r <= rd_idx_r[bms_pkg::IDX_W-1:0];
    end
  end

  // outcome of the finished item
  always_comb begin
    fin_cnt = cnt_r;
    fin_ok  = 1'b0;
    case (act_r)
      bms_pkg::ACT_ADD: begin
        fin_ok = room;
        if (room) begin
          fin_cnt = cnt_r + 1'b1;
        end
      end
      bms_pkg::ACT_REMOVE: begin
        fin_ok = found_r;
        if (found_r) begin
          fin_cnt = cnt_r - 1'b1;
        end
      end
      bms_pkg::ACT_COUNT: begin
        fin_ok = found_r;
      end
      bms_pkg::ACT_CLEAR: begin
        fin_cnt = '0;
      end
      default: begin
        fin_cnt = cnt_r;
      end
    endcase
  end

  assign req_ready       = (state_r == S_IDLE);
  assign res_valid       = (state_r == S_FIN);
  assign res.ok          = fin_ok;
  assign res.match_count = bms_pkg::OUT_CNT_W'(match_r);
  assign res.fill_count  = bms_pkg::OUT_CNT_W'(fin_cnt);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    act_nxt    = act_r;
    val_nxt    = val_r;
    cnt_nxt    = cnt_r;
    rd_idx_nxt = rd_idx_r;
    match_nxt  = match_r;
    found_nxt  = found_r;
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          act_nxt    = req.action;
          val_nxt    = req.value;
          rd_idx_nxt = '0;
          match_nxt  = '0;
          found_nxt  = 1'b0;
          state_nxt  = (req.action == bms_pkg::ACT_CLEAR) ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (hit) begin
          match_nxt = match_r + 1'b1;
          found_nxt = 1'b1;
        end
        if (!issue && !data_vld_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (res_ready) begin
          cnt_nxt   = fin_cnt;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      data_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      data_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    val_r    <= val_nxt;
    rd_idx_r <= rd_idx_nxt;
    match_r  <= match_nxt;
    found_r  <= found_nxt;
  end

endmodule

// ===== src/bounded_multiset_store.sv =====
// top level: stream ports, request capture and result output register
//
//  channel | dir | tdata                                   | tuser
//  in_     | in  | [31:0] item_value                       | [1:0] action
//  out_    | out | [0] ok, [5:1] match_count, [10:6] fill  | -
//
// an add, remove or count request runs a scan over the stored entries, reading one stored
// entry per cycle through the single read port; a clear skips the scan and passes straight
// to its result
// in_tready rises as the result enters the output register
// reset empties the bag at once; no clearing pass runs over the entry memory
// a stalled result holds in the output register and the next request may already be taken
module bounded_multiset_store (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] item_value
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [0] ok, [5:1] match_count, [10:6] fill_count, rest zero
);

  bms_pkg::bms_req_t req;
  bms_pkg::bms_res_t res;
  logic              res_valid;
  logic              res_ready;
  logic              out_valid_r;
  bms_pkg::bms_res_t out_res_r;

  // unpack the request
  assign req.action = bms_pkg::bms_action_t'(in_tuser);
  assign req.value  = in_tdata[bms_pkg::ITEM_WIDTH-1:0];

  bms_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req       (req),
    .req_ready (in_tready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // output register takes a result when empty or draining
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  // pack the result
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.fill_count, out_res_r.match_count, out_res_r.ok};

endmodule

// ===== src/bms_checker.sv =====
// port-level checker for the bounded multiset store, bound to the top level
module bms_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // fill count never exceeds capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[10:6] <= 5'(bms_pkg::BAG_DEPTH)))
    else $error("fill count above capacity");

  // matches seen before the action exceed the bag left after it by at most one
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[5:1]} <= {1'b0, out_tdata[10:6]} + 6'd1))
    else $error("match count inconsistent with fill count");

  // one request at a time: ready drops after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // reset leaves no result pending
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind bounded_multiset_store bms_port_checker u_bms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/bms_checker.sv =====
// bag predictor and result checker for the bounded multiset store streams
`timescale 1ns / 100ps

module bms_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] item_value
  input  logic [1:0]  in_tuser,   // [1:0] action
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [0] ok, [5:1] match_count, [10:6] fill_count
  output int          fail_count,
  output int          pending_results
);

  // predicted bag contents, oldest entry at index 0
  logic [bms_pkg::ITEM_WIDTH-1:0] bag_entries [bms_pkg::BAG_DEPTH];
  int                             bag_fill;

  // results predicted for accepted requests, oldest first
  bms_pkg::bms_res_t bag_result_q [$];
  bms_pkg::bms_res_t seen_res;
  bms_pkg::bms_res_t want_res;

  initial fail_count = 0;

  // apply one request to the predicted bag and return the result it should produce
  function automatic bms_pkg::bms_res_t apply_bag_request(
      bms_pkg::bms_action_t act, logic [bms_pkg::ITEM_WIDTH-1:0] val);
    bms_pkg::bms_res_t res;
    int                hits;
    int                first_hit;
    int                i;
    res       = '0;
    hits      = 0;
    first_hit = -1;
    if (act == bms_pkg::ACT_CLEAR) begin
      bag_fill = 0;
    end else begin
      // matches are counted before the bag changes
      for (i = 0; i < bag_fill; i++) begin
        if (bag_entries[i] == val) begin
          hits++;
          if (first_hit < 0) first_hit = i;
        end
      end
      case (act)
        bms_pkg::ACT_ADD: begin
          if (bag_fill < bms_pkg::BAG_DEPTH) begin
            bag_entries[bag_fill] = val;
            bag_fill++;
            res.ok = 1'b1;
          end
        end
        bms_pkg::ACT_REMOVE: begin
          // drop the first match and close the gap
          if (first_hit >= 0) begin
            for (i = first_hit; i < bag_fill - 1; i++) bag_entries[i] = bag_entries[i + 1];
            bag_fill--;
            res.ok = 1'b1;
          end
        end
        default: begin
          res.ok = (hits > 0);
        end
      endcase
    end
    res.match_count = bms_pkg::OUT_CNT_W'(hits);
    res.fill_count  = bms_pkg::OUT_CNT_W'(bag_fill);
    return res;
  endfunction

  // watch both channels at each edge; results are checked before new requests are queued
  always @(posedge clk) begin
    if (!rst_n) begin
      bag_fill = 0;
      bag_result_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen_res.ok          = out_tdata[0];
        seen_res.match_count = out_tdata[5:1];
        seen_res.fill_count  = out_tdata[10:6];
        if (bag_result_q.size() == 0) begin
          $display("%0t: result with none pending: ok=%0d match=%0d fill=%0d", $time,
                   seen_res.ok, seen_res.match_count, seen_res.fill_count);
          fail_count++;
        end else begin
          want_res = bag_result_q.pop_front();
          if (seen_res !== want_res) begin
            $display({"%0t: result mismatch expected ok=%0d match=%0d fill=%0d,",
                      " got ok=%0d match=%0d fill=%0d"},
                     $time, want_res.ok, want_res.match_count, want_res.fill_count,
                     seen_res.ok, seen_res.match_count, seen_res.fill_count);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        bag_result_q.push_back(apply_bag_request(bms_pkg::bms_action_t'(in_tuser),
                                                 in_tdata[bms_pkg::ITEM_WIDTH-1:0]));
      end
    end
    pending_results = bag_result_q.size();
  end

endmodule

// ===== dv/tb_bounded_multiset_store.sv =====
// testbench top: clock, reset, request and stall stimulus, and the final verdict
`timescale 1ns / 100ps

module tb_bounded_multiset_store;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PER_PHASE = 150;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = bms_pkg::ACT_ADD;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  int fail_count;
  int pending_results;

  // idling odds in percent, changed per phase
  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;

  logic [31:0] value_pool [4];

  always #5 clk = ~clk;

  bounded_multiset_store dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  bms_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // offer one request, with a random idle gap first, and wait for it to be taken
  task automatic send_request(input bms_pkg::bms_action_t act, input logic [31:0] val);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
  endtask

  // random requests in alternating grow and shrink stretches, values mostly from a small pool
  task automatic send_random(input int n);
    int                   j;
    int                   roll;
    bms_pkg::bms_action_t act;
    logic [31:0]          val;
    value_pool[0] = $urandom();
    value_pool[1] = $urandom();
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (j = 0; j < n; j++) begin
      roll = $urandom_range(0, 99);
      if ((j / 40) % 2 == 0) begin
        act = (roll < 60) ? bms_pkg::ACT_ADD : (roll < 75) ? bms_pkg::ACT_REMOVE :
              (roll < 97) ? bms_pkg::ACT_COUNT : bms_pkg::ACT_CLEAR;
      end else begin
        act = (roll < 20) ? bms_pkg::ACT_ADD : (roll < 65) ? bms_pkg::ACT_REMOVE :
              (roll < 93) ? bms_pkg::ACT_COUNT : bms_pkg::ACT_CLEAR;
      end
      val = ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, 3)] : $urandom();
      send_request(act, val);
    end
  endtask

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    int k;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // main sequence
  initial begin
    int k;
    int waited;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty bag, duplicates, remove shifting, full bag, clear
    send_request(bms_pkg::ACT_COUNT, 32'h0000_0000);
    send_request(bms_pkg::ACT_REMOVE, 32'hFFFF_FFFF);
    send_request(bms_pkg::ACT_ADD, 32'h0000_0000);
    send_request(bms_pkg::ACT_ADD, 32'hFFFF_FFFF);
    send_request(bms_pkg::ACT_ADD, 32'h0000_0000);
    send_request(bms_pkg::ACT_REMOVE, 32'h0000_0000);
    send_request(bms_pkg::ACT_COUNT, 32'h0000_0000);
    for (k = 0; k < bms_pkg::BAG_DEPTH - 2; k++) send_request(bms_pkg::ACT_ADD, 32'hFFFF_FFFF);
    send_request(bms_pkg::ACT_ADD, 32'h8000_0001);
    send_request(bms_pkg::ACT_COUNT, 32'hFFFF_FFFF);
    send_request(bms_pkg::ACT_CLEAR, 32'h1234_5678);

    // random, no idling, opening with a long receiver hold-off
    hold_req = 1'b1;
    send_random(RANDOM_PER_PHASE);

    // random, sender idling
    idle_pct  = 59;
    stall_pct = 0;
    send_random(RANDOM_PER_PHASE);

    // random, receiver stalling
    idle_pct  = 0;
    stall_pct = 59;
    send_random(RANDOM_PER_PHASE);

    // random, both sides idling
    idle_pct  = 32;
    stall_pct = 32;
    send_random(RANDOM_PER_PHASE);
    in_tvalid <= 1'b0;

    // drain the results still in flight
    stall_pct = 0;
    waited    = 0;
    while (pending_results != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_results == 0) begin
      $display("bounded_multiset_store verification clean");
    end else begin
      $display("bounded_multiset_store verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("bounded_multiset_store verification failed");
    $finish;
  end

endmodule
